### design/chunked_message_reassembly_tracker_macros.svh
// Assertion macros for the chunked message reassembly tracker.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef CHUNKED_MESSAGE_REASSEMBLY_TRACKER_MACROS_SVH
`define CHUNKED_MESSAGE_REASSEMBLY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CMRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmrt assertion failed");
// next-cycle implication
`define CMRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmrt assertion failed");
`else
`define CMRT_ASSERT_IMPL(label, ante, cons)
`define CMRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/cmrt_pkg.sv
// Shared types and constants for the chunked message reassembly tracker.
// No dependencies.
package cmrt_pkg;

  localparam int MAX_CHUNKS_DEF   = 64;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int NUM_COUNTERS     = 7;

  localparam logic [31:0] GAP_RESET   = 32'd1000;
  localparam logic [7:0]  LEGACY_MARK = 8'h7B;

  // configuration register indexes
  localparam logic [7:0] REG_RESTART_GAP  = 8'd0;
  localparam logic [7:0] REG_HEADER_BYTES = 8'd1;

  // statistics counter slots
  localparam logic [2:0] CNT_MALFORMED  = 3'd0;
  localparam logic [2:0] CNT_LEGACY     = 3'd1;
  localparam logic [2:0] CNT_OLD        = 3'd2;
  localparam logic [2:0] CNT_RESTART    = 3'd3;
  localparam logic [2:0] CNT_MISMATCH   = 3'd4;
  localparam logic [2:0] CNT_INCOMPLETE = 3'd5;
  localparam logic [2:0] CNT_COMPLETE   = 3'd6;

  typedef enum logic [2:0] {
    ST_MALFORMED = 3'd0,
    ST_LEGACY    = 3'd1,
    ST_OLD       = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_STORED    = 3'd4,
    ST_COMPLETE  = 3'd5
  } status_e;

endpackage

### design/chunked_message_reassembly_tracker.sv
// Top level of the chunked message reassembly tracker.
// Depends on cmrt_pkg and chunked_message_reassembly_tracker_macros.svh.
`include "chunked_message_reassembly_tracker_macros.svh"

// One parsed datagram header enters per request on the input channel and
// produces exactly one result request. Each header is classified as
// malformed, legacy text (first byte 0x7B), old (dropped), chunk count
// mismatch (tracker cleared), chunk stored or message complete. The tracker
// keeps the id of the message being assembled, the chunk count it declared,
// a bitmap of chunks already seen and their count; an id that falls more
// than restart_gap below the active id is a sender restart and opens a new
// message. Seven wrapping statistics counters are reported with every
// result, together with the held chunk count, as they stand after that
// header. Throughput is one header per clock while results are taken:
// a header is captured in an input register, classified and folded into
// the tracker state by a single pass of logic (one 32-bit subtract and
// compare for the restart check, one map bit lookup), and the result is
// held in an output register. A result the receiver has not taken holds
// the stage, and in_ready_o drops once the input register is also full.
// Configuration writes are always accepted (cfg_ready_o
// is tied high) and must only be issued while the block is idle; register
// 0 is restart_gap (reset 1000), register 1 is header_bytes (reset 0),
// other indexes are ignored. Payload bytes are not stored here.
module chunked_message_reassembly_tracker
  import cmrt_pkg::*;
#(
  parameter int MAX_CHUNKS   = MAX_CHUNKS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] datagram_bytes_i,
  input  logic [7:0]  first_byte_i,
  input  logic        header_ok_i,
  input  logic [31:0] message_id_i,
  input  logic [15:0] chunk_index_i,
  input  logic [15:0] chunk_count_i,
  input  logic [15:0] payload_bytes_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        restart_seen_o,
  output logic [6:0]  chunks_held_o,
  output logic [31:0] malformed_total_o,
  output logic [31:0] legacy_total_o,
  output logic [31:0] old_total_o,
  output logic [31:0] restart_total_o,
  output logic [31:0] mismatch_total_o,
  output logic [31:0] incomplete_total_o,
  output logic [31:0] complete_total_o
);

  // count width holds 0..MAX_CHUNKS, index width addresses the map
  localparam int CW   = $clog2(MAX_CHUNKS + 1);
  localparam int IDXW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] restart_gap_q;
  logic [7:0]  header_bytes_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_gap_q  <= GAP_RESET;
      header_bytes_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RESTART_GAP:  restart_gap_q  <= cfg_data_i;
        REG_HEADER_BYTES: header_bytes_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register -> classify/update -> result register
  // ---------------------------------------------------------------------
  logic in_vld_q;
  logic out_vld_q;
  logic advance;

  // the stage moves when its result slot is free or being drained
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  logic [15:0] size_q;
  logic [7:0]  first_q;
  logic        hdr_ok_q;
  logic [31:0] id_q;
  logic [15:0] idx_q;
  logic [15:0] cnt_q;
  logic [15:0] pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      size_q   <= datagram_bytes_i;
      first_q  <= first_byte_i;
      hdr_ok_q <= header_ok_i;
      id_q     <= message_id_i;
      idx_q    <= chunk_index_i;
      cnt_q    <= chunk_count_i;
      pay_q    <= payload_bytes_i;
    end
  end

  // ---------------------------------------------------------------------
  // Tracker state
  // ---------------------------------------------------------------------
  logic [31:0]         active_id_q,      active_id_d;
  logic [CW-1:0]       expected_total_q, expected_total_d;
  logic [CW-1:0]       held_count_q,     held_count_d;
  logic [MAX_CHUNKS-1:0] held_map_q,     held_map_d;
  logic [COUNTER_BITS-1:0] stat_q [NUM_COUNTERS];
  logic [COUNTER_BITS-1:0] stat_d [NUM_COUNTERS];

  status_e status_q, status_d;
  logic    restart_q;

  // ---------------------------------------------------------------------
  // Classification
  // ---------------------------------------------------------------------
  logic is_empty, is_legacy, is_bad, hdr_good;
  logic restart, start_new, is_old, mismatch, stored, complete;
  logic abandon;
  logic [CW-1:0]         eff_exp, eff_held, held_after;
  logic [MAX_CHUNKS-1:0] eff_map, bit_mask;
  logic                  new_bit;
  logic [NUM_COUNTERS-1:0] inc;

  always_comb begin
    is_empty  = (size_q == '0);
    is_legacy = !is_empty && (first_q == LEGACY_MARK);
    // size must cover the header and payload must fill the rest exactly
    is_bad    = !hdr_ok_q
             || (cnt_q == '0)
             || ({1'b0, cnt_q} > 17'(MAX_CHUNKS))
             || (idx_q >= cnt_q)
             || (pay_q == '0)
             || (size_q < 16'(header_bytes_q))
             || (pay_q != (size_q - 16'(header_bytes_q)));
    hdr_good  = !is_empty && !is_legacy && !is_bad;

    // large backward jump in id means the sender restarted
    restart   = hdr_good && (active_id_q != '0) && (id_q < active_id_q)
             && ((active_id_q - id_q) > restart_gap_q);
    start_new = hdr_good && ((active_id_q == '0) || (id_q > active_id_q) || restart);
    is_old    = hdr_good && !start_new && (id_q < active_id_q);
    mismatch  = hdr_good && !start_new && !is_old && (cnt_q != 16'(expected_total_q));
    stored    = hdr_good && !is_old && !mismatch;

    // partly filled message being dropped
    abandon   = (active_id_q != '0) && (held_count_q != '0)
             && (held_count_q < expected_total_q);

    eff_exp    = start_new ? CW'(cnt_q) : expected_total_q;
    eff_held   = start_new ? '0 : held_count_q;
    eff_map    = start_new ? '0 : held_map_q;
    bit_mask   = MAX_CHUNKS'(1) << idx_q[IDXW-1:0];
    new_bit    = ~|(eff_map & bit_mask);
    held_after = eff_held + CW'(new_bit);
    complete   = stored && (held_after == eff_exp);

    inc                 = '0;
    inc[CNT_MALFORMED]  = is_empty || (!is_legacy && is_bad);
    inc[CNT_LEGACY]     = is_legacy;
    inc[CNT_OLD]        = is_old;
    inc[CNT_RESTART]    = restart;
    inc[CNT_MISMATCH]   = mismatch;
    inc[CNT_INCOMPLETE] = (start_new || mismatch) && abandon;
    inc[CNT_COMPLETE]   = complete;
  end

  // next tracker state
  always_comb begin
    active_id_d      = active_id_q;
    expected_total_d = expected_total_q;
    held_count_d     = held_count_q;
    held_map_d       = held_map_q;
    if (mismatch || complete) begin
      active_id_d      = '0;
      expected_total_d = '0;
      held_count_d     = '0;
      held_map_d       = '0;
    end else if (stored) begin
      active_id_d      = id_q;
      expected_total_d = eff_exp;
      held_count_d     = held_after;
      held_map_d       = eff_map | bit_mask;
    end
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      stat_d[k] = stat_q[k] + COUNTER_BITS'(inc[k]);
    end
  end

  // result code
  always_comb begin
    if (is_empty) begin
      status_d = ST_MALFORMED;
    end else if (is_legacy) begin
      status_d = ST_LEGACY;
    end else if (is_bad) begin
      status_d = ST_MALFORMED;
    end else if (is_old) begin
      status_d = ST_OLD;
    end else if (mismatch) begin
      status_d = ST_MISMATCH;
    end else if (complete) begin
      status_d = ST_COMPLETE;
    end else begin
      status_d = ST_STORED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_id_q      <= '0;
      expected_total_q <= '0;
      held_count_q     <= '0;
      held_map_q       <= '0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        stat_q[k] <= '0;
      end
    end else if (advance) begin
      active_id_q      <= active_id_d;
      expected_total_q <= expected_total_d;
      held_count_q     <= held_count_d;
      held_map_q       <= held_map_d;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        stat_q[k] <= stat_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q  <= status_d;
      restart_q <= restart;
    end
  end

  // ---------------------------------------------------------------------
  // Outputs: counters and held count only change with a new result, so
  // they are read straight from the state registers.
  // ---------------------------------------------------------------------
  assign out_valid_o        = out_vld_q;
  assign status_o           = status_q;
  assign restart_seen_o     = restart_q;
  assign chunks_held_o      = 7'(held_count_q);
  assign malformed_total_o  = 32'(stat_q[CNT_MALFORMED]);
  assign legacy_total_o     = 32'(stat_q[CNT_LEGACY]);
  assign old_total_o        = 32'(stat_q[CNT_OLD]);
  assign restart_total_o    = 32'(stat_q[CNT_RESTART]);
  assign mismatch_total_o   = 32'(stat_q[CNT_MISMATCH]);
  assign incomplete_total_o = 32'(stat_q[CNT_INCOMPLETE]);
  assign complete_total_o   = 32'(stat_q[CNT_COMPLETE]);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a full message is retired at once, so the count never reaches the total
  `CMRT_ASSERT_IMPL(a_held_below_total, 1'b1,
                    (held_count_q == '0) || (held_count_q < expected_total_q))
  // map population and held count track each other
  `CMRT_ASSERT_IMPL(a_map_matches_count, 1'b1,
                    $countones(held_map_q) == int'(held_count_q))
  // a restart always opens a new message, never an old drop or mismatch
  `CMRT_ASSERT_IMPL(a_restart_opens_msg, out_vld_q && restart_q,
                    (status_q == ST_STORED) || (status_q == ST_COMPLETE))
  // tracker state only moves together with a new result
  `CMRT_ASSERT_NEXT(a_state_holds_on_stall, !advance,
                    $stable(held_map_q) && $stable(active_id_q))

endmodule

### tb/tb.sv
// Testbench for chunked_message_reassembly_tracker: random and directed datagram headers
// checked against a cycle-free predictor of the tracker state and statistics counters.
// Depends on cmrt_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import cmrt_pkg::*;

  localparam int STALL_LIMIT  = 2000;   // cycles without any accepted request
  localparam int DRAIN_CYCLES = 6;      // pipeline depth plus margin
  localparam int SHOW_LIMIT   = 40;     // mismatch lines printed before going quiet
  localparam logic [7:0] REG_UNUSED = 8'hFF;

  // one parsed datagram header, as it travels on the input channel
  typedef struct {
    logic [15:0] dgram_bytes;
    logic [7:0]  first_byte;
    logic        header_ok;
    logic [31:0] msg_id;
    logic [15:0] chunk_idx;
    logic [15:0] chunk_cnt;
    logic [15:0] pay_bytes;
  } dgram_hdr_t;

  // one classification result, as it leaves the block
  typedef struct {
    logic [2:0]                     status;
    logic                           restart;
    logic [6:0]                     held;
    logic [NUM_COUNTERS-1:0][31:0]  totals;
  } verdict_t;

  // Tracker predictor: mirrors the reassembly state and counters and keeps the
  // verdicts still owed by the block, oldest first.
  class tracker_predictor;
    logic [31:0] gap;
    logic [7:0]  hdr_len;
    logic [31:0] cur_id;
    logic [6:0]  want;
    logic [6:0]  have;
    logic [63:0] seen;
    logic [NUM_COUNTERS-1:0][31:0] tally;
    verdict_t    verdicts_due[$];
    int          errors;
    int          shown;
    int          headers;
    int          outcomes;
    string       total_names[NUM_COUNTERS] = '{"malformed_total", "legacy_total",
      "old_total", "restart_total", "mismatch_total", "incomplete_total", "complete_total"};

    function new();
      gap      = GAP_RESET;
      hdr_len  = 8'd0;
      tally    = '0;
      errors   = 0;
      shown    = 0;
      headers  = 0;
      outcomes = 0;
      clear_msg();
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] data);
      if (idx == REG_RESTART_GAP) gap = data;
      else if (idx == REG_HEADER_BYTES) hdr_len = data[7:0];
    endfunction

    function void tick(logic [2:0] slot);
      tally[slot] = tally[slot] + 32'd1;
    endfunction

    function void clear_msg();
      cur_id = '0;
      want   = '0;
      have   = '0;
      seen   = '0;
    endfunction

    // a message with some but not all chunks counts as abandoned
    function void close_partial();
      if (cur_id != 0 && have != 0 && have < want) tick(CNT_INCOMPLETE);
    endfunction

    function int waiting();
      return verdicts_due.size();
    endfunction

    function void predict_header(dgram_hdr_t h);
      verdict_t v;
      status_e  st;
      logic     restart;
      restart = 1'b0;
      headers++;
      if (h.dgram_bytes == 16'd0) begin
        tick(CNT_MALFORMED);
        st = ST_MALFORMED;
      end else if (h.first_byte == LEGACY_MARK) begin
        tick(CNT_LEGACY);
        st = ST_LEGACY;
      end else if (!h.header_ok || h.chunk_cnt == 16'd0 ||
                   h.chunk_cnt > 16'(MAX_CHUNKS_DEF) || h.chunk_idx >= h.chunk_cnt ||
                   h.pay_bytes == 16'd0 || h.dgram_bytes < 16'(hdr_len) ||
                   h.pay_bytes != h.dgram_bytes - 16'(hdr_len)) begin
        tick(CNT_MALFORMED);
        st = ST_MALFORMED;
      end else begin
        restart = (cur_id != 0) && (h.msg_id < cur_id) && ((cur_id - h.msg_id) > gap);
        if (restart) tick(CNT_RESTART);
        if (cur_id == 0 || h.msg_id > cur_id || restart) begin
          close_partial();
          cur_id = h.msg_id;
          want   = h.chunk_cnt[6:0];
          have   = '0;
          seen   = '0;
          st     = ST_STORED;
        end else if (h.msg_id < cur_id) begin
          tick(CNT_OLD);
          st = ST_OLD;
        end else begin
          st = ST_STORED;
        end
        if (st == ST_STORED) begin
          if (h.chunk_cnt != {9'd0, want}) begin
            tick(CNT_MISMATCH);
            close_partial();
            clear_msg();
            st = ST_MISMATCH;
          end else begin
            if (!seen[h.chunk_idx[5:0]]) begin
              seen[h.chunk_idx[5:0]] = 1'b1;
              have++;
            end
            if (have == want) begin
              tick(CNT_COMPLETE);
              clear_msg();
              st = ST_COMPLETE;
            end
          end
        end
      end
      v.status  = st;
      v.restart = restart;
      v.held    = have;
      v.totals  = tally;
      verdicts_due.push_back(v);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    task check_verdict(verdict_t got);
      verdict_t exp_v;
      int       j;
      outcomes++;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", outcomes));
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (got.status !== exp_v.status)
        report_mismatch($sformatf("result %0d status: got %0d expected %0d",
                                  outcomes, got.status, exp_v.status));
      if (got.restart !== exp_v.restart)
        report_mismatch($sformatf("result %0d restart_seen: got %0b expected %0b",
                                  outcomes, got.restart, exp_v.restart));
      if (got.held !== exp_v.held)
        report_mismatch($sformatf("result %0d chunks_held: got %0d expected %0d",
                                  outcomes, got.held, exp_v.held));
      for (j = 0; j < NUM_COUNTERS; j++)
        if (got.totals[j] !== exp_v.totals[j])
          report_mismatch($sformatf("result %0d %s: got %0d expected %0d", outcomes,
                                    total_names[j], got.totals[j], exp_v.totals[j]));
    endtask
  endclass

  // DUT signals; every input starts at a known value
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] datagram_bytes_i = '0;
  logic [7:0]  first_byte_i = '0;
  logic        header_ok_i = 1'b0;
  logic [31:0] message_id_i = '0;
  logic [15:0] chunk_index_i = '0;
  logic [15:0] chunk_count_i = '0;
  logic [15:0] payload_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        restart_seen_o;
  logic [6:0]  chunks_held_o;
  logic [31:0] malformed_total_o;
  logic [31:0] legacy_total_o;
  logic [31:0] old_total_o;
  logic [31:0] restart_total_o;
  logic [31:0] mismatch_total_o;
  logic [31:0] incomplete_total_o;
  logic [31:0] complete_total_o;

  chunked_message_reassembly_tracker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .datagram_bytes_i   (datagram_bytes_i),
    .first_byte_i       (first_byte_i),
    .header_ok_i        (header_ok_i),
    .message_id_i       (message_id_i),
    .chunk_index_i      (chunk_index_i),
    .chunk_count_i      (chunk_count_i),
    .payload_bytes_i    (payload_bytes_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .restart_seen_o     (restart_seen_o),
    .chunks_held_o      (chunks_held_o),
    .malformed_total_o  (malformed_total_o),
    .legacy_total_o     (legacy_total_o),
    .old_total_o        (old_total_o),
    .restart_total_o    (restart_total_o),
    .mismatch_total_o   (mismatch_total_o),
    .incomplete_total_o (incomplete_total_o),
    .complete_total_o   (complete_total_o)
  );

  tracker_predictor sb = new();

  // Handshake flags are sampled at the falling edge, where every signal is
  // stable, and read at the next rising edge when the request actually moves.
  bit          in_fire;
  bit          out_fire;
  bit          cfg_fire;
  bit          calm;            // no idling on either side while set
  int          quiet_cycles;
  int          settings;
  logic [31:0] gen_id = 32'd1000;  // id the random message stream is walking from

  always #5 clk_i = ~clk_i;

  // receiver: random back-pressure, none during the calm stretch
  always @(posedge clk_i)
    out_ready_i <= calm || ($urandom_range(99) >= 34);

  // Monitor: every result request is checked at the falling edge before the
  // edge that accepts it. The watchdog stands last in this block.
  always @(negedge clk_i) begin : monitor
    verdict_t got;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    if (out_fire) begin
      got.status = status_o;
      got.restart = restart_seen_o;
      got.held = chunks_held_o;
      got.totals[CNT_MALFORMED]  = malformed_total_o;
      got.totals[CNT_LEGACY]     = legacy_total_o;
      got.totals[CNT_OLD]        = old_total_o;
      got.totals[CNT_RESTART]    = restart_total_o;
      got.totals[CNT_MISMATCH]   = mismatch_total_o;
      got.totals[CNT_INCOMPLETE] = incomplete_total_o;
      got.totals[CNT_COMPLETE]   = complete_total_o;
      sb.check_verdict(got);
    end
    if (!rst_ni || in_fire || out_fire || cfg_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.waiting());
      $display("Regression FAIL");
      $finish;
    end
  end

  // register write; only issued while the tracker is drained
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_fire);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one header request. Valid stays high from one header to the next
  // unless an idle cycle is drawn, so it never drops and rises in one step.
  task automatic push_header(dgram_hdr_t h);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    datagram_bytes_i <= h.dgram_bytes;
    first_byte_i     <= h.first_byte;
    header_ok_i      <= h.header_ok;
    message_id_i     <= h.msg_id;
    chunk_index_i    <= h.chunk_idx;
    chunk_count_i    <= h.chunk_cnt;
    payload_bytes_i  <= h.pay_bytes;
    do @(posedge clk_i); while (!in_fire);
    sb.predict_header(h);
  endtask

  // stop sending and wait until every owed result has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic dgram_hdr_t mk(logic [15:0] dgram_bytes, logic [7:0] first_byte,
                                    logic ok, logic [31:0] id, logic [15:0] idx,
                                    logic [15:0] cnt, logic [15:0] pay);
    dgram_hdr_t h;
    h.dgram_bytes = dgram_bytes;
    h.first_byte  = first_byte;
    h.header_ok   = ok;
    h.msg_id      = id;
    h.chunk_idx   = idx;
    h.chunk_cnt   = cnt;
    h.pay_bytes   = pay;
    return h;
  endfunction

  // well-formed chunk under the current header length
  function automatic dgram_hdr_t good_chunk(logic [31:0] id, int idx, int cnt);
    dgram_hdr_t h;
    int         pay;
    if ($urandom_range(3) == 0) pay = $urandom_range(16, 1);
    else pay = $urandom_range(65535 - int'(sb.hdr_len), 1);
    h = mk(16'(pay + int'(sb.hdr_len)), 8'h00, 1'b1, id, 16'(idx), 16'(cnt), 16'(pay));
    do h.first_byte = 8'($urandom); while (h.first_byte == LEGACY_MARK);
    return h;
  endfunction

  // one rejected or legacy header, with a flavor of bad layout drawn at random
  function automatic dgram_hdr_t noisy_header();
    dgram_hdr_t h;
    h = good_chunk($urandom, 0, $urandom_range(64, 1));
    case ($urandom_range(7))
      0: begin
        h = mk('0, 8'($urandom), 1'($urandom), $urandom, 16'($urandom), 16'($urandom),
               16'($urandom));
      end
      1: begin
        h.first_byte  = LEGACY_MARK;
        h.dgram_bytes = 16'($urandom_range(65535, 1));
      end
      2: h.header_ok = 1'b0;
      3: begin
        h.chunk_cnt = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 65));
      end
      4: h.chunk_idx = 16'($urandom_range(65535, int'(h.chunk_cnt)));
      5: begin
        h.pay_bytes   = '0;
        h.dgram_bytes = 16'(sb.hdr_len);
      end
      6: begin
        if (sb.hdr_len != 0 && $urandom_range(1) == 0)
          h.dgram_bytes = 16'($urandom_range(int'(sb.hdr_len) - 1));
        else
          h.dgram_bytes = h.dgram_bytes + 16'($urandom_range(50, 1));
      end
      default: begin
        h = mk(16'($urandom), 8'($urandom), 1'($urandom), $urandom, 16'($urandom),
               16'($urandom), 16'($urandom));
      end
    endcase
    return h;
  endfunction

  // One message in shuffled chunk order, sometimes cut short, with repeats,
  // count mismatches and stray headers mixed in.
  task automatic run_message();
    int          order[64];
    int          cnt;
    int          alt;
    int          stop;
    int          k;
    int          j;
    int          tmp;
    int          roll;
    logic [31:0] id;
    roll = $urandom_range(99);
    if (roll < 55)      id = gen_id + 32'($urandom_range(40, 1));
    else if (roll < 65) id = gen_id;
    else if (roll < 75) id = gen_id - 32'($urandom_range(30, 1));
    else if (roll < 85) id = gen_id - 32'($urandom_range(100000, 1001));
    else if (roll < 95) id = $urandom;
    else if (roll < 97) id = '0;
    else                id = 32'hFFFF_FFFF - 32'($urandom_range(3));
    gen_id = id;
    cnt = ($urandom_range(11) == 0) ? $urandom_range(64, 17) : $urandom_range(6, 1);
    alt = (cnt == MAX_CHUNKS_DEF) ? cnt - 1 : cnt + 1;
    for (k = 0; k < cnt; k++) order[k] = k;
    for (k = cnt - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    stop = ($urandom_range(99) < 15) ? $urandom_range(cnt - 1) : cnt;
    for (k = 0; k < stop; k++) begin
      roll = $urandom_range(99);
      if (roll < 4) push_header(good_chunk(id, order[k] % alt, alt));
      else if (roll < 9) push_header(noisy_header());
      else if (roll < 15 && k > 0) push_header(good_chunk(id, order[$urandom_range(k - 1)], cnt));
      push_header(good_chunk(id, order[k], cnt));
    end
  endtask

  task automatic run_phase(int n);
    int start;
    start = sb.headers;
    while (sb.headers - start < n) begin
      if ($urandom_range(99) < 15) push_header(noisy_header());
      else run_message();
    end
  endtask

  initial begin
    settings = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: every rejection rule, id zero, repeats, mismatch, old, restart
    write_reg(REG_RESTART_GAP, GAP_RESET);
    write_reg(REG_HEADER_BYTES, 32'd4);
    settings++;
    push_header(mk(16'd0, 8'h00, 1'b1, 32'd1, 16'd0, 16'd1, 16'd0));          // empty
    push_header(mk(16'hFFFF, LEGACY_MARK, 1'b0, '0, '0, '0, '0));              // legacy text
    push_header(mk(16'd10, 8'hFF, 1'b0, 32'd7, 16'd0, 16'd1, 16'd6));          // parser reject
    push_header(mk(16'd10, 8'h01, 1'b1, 32'd7, 16'd0, 16'd0, 16'd6));          // zero chunks
    push_header(mk(16'd10, 8'h01, 1'b1, 32'd7, 16'd0, 16'd65, 16'd6));         // too many chunks
    push_header(mk(16'd10, 8'h01, 1'b1, 32'd7, 16'd3, 16'd3, 16'd6));          // index past count
    push_header(mk(16'd4, 8'h01, 1'b1, 32'd7, 16'd0, 16'd1, 16'd0));           // empty payload
    push_header(mk(16'd2, 8'h01, 1'b1, 32'd7, 16'd0, 16'd1, 16'hFFFE));        // shorter than header
    push_header(mk(16'd11, 8'h01, 1'b1, 32'd7, 16'd0, 16'd1, 16'd6));          // length disagrees
    push_header(mk(16'd5, 8'h00, 1'b1, 32'd0, 16'd0, 16'd1, 16'd1));           // id zero completes
    push_header(mk(16'd5, 8'h02, 1'b1, 32'd0, 16'd0, 16'd2, 16'd1));           // id zero restarts
    push_header(mk(16'd5, 8'h02, 1'b1, 32'd0, 16'd1, 16'd2, 16'd1));
    push_header(mk(16'd9, 8'h03, 1'b1, 32'd100, 16'd0, 16'd3, 16'd5));
    push_header(mk(16'd9, 8'h03, 1'b1, 32'd100, 16'd0, 16'd3, 16'd5));         // repeated chunk
    push_header(mk(16'd9, 8'h03, 1'b1, 32'd100, 16'd2, 16'd3, 16'd5));
    push_header(mk(16'd9, 8'h03, 1'b1, 32'd100, 16'd1, 16'd3, 16'd5));         // completes
    push_header(mk(16'd9, 8'h04, 1'b1, 32'd200, 16'd1, 16'd2, 16'd5));
    push_header(mk(16'd9, 8'h04, 1'b1, 32'd200, 16'd0, 16'd3, 16'd5));         // count mismatch
    push_header(mk(16'd9, 8'h05, 1'b1, 32'd500, 16'd0, 16'd2, 16'd5));
    push_header(mk(16'd9, 8'h05, 1'b1, 32'd499, 16'd1, 16'd2, 16'd5));         // old, dropped
    push_header(mk(16'd9, 8'h06, 1'b1, 32'd5000, 16'd0, 16'd2, 16'd5));        // abandons 500
    push_header(mk(16'd9, 8'h06, 1'b1, 32'd10, 16'd0, 16'd2, 16'd5));          // sender restart
    push_header(mk(16'hFFFF, 8'h7A, 1'b1, 32'hFFFF_FFFF, 16'd63, 16'd64, 16'd65531));
    push_header(mk(16'd5, 8'h80, 1'b1, 32'hFFFF_FFFF, 16'd0, 16'd64, 16'd1));
    settle();

    write_reg(REG_HEADER_BYTES, 32'd0);
    settings++;
    run_phase(380);
    settle();

    // every lower id is a restart
    write_reg(REG_RESTART_GAP, 32'd0);
    write_reg(REG_HEADER_BYTES, 32'd255);
    settings++;
    run_phase(380);
    settle();

    // restarts impossible; unused index must be ignored; no idling here
    write_reg(REG_RESTART_GAP, 32'hFFFF_FFFF);
    write_reg(REG_HEADER_BYTES, 32'd0);
    write_reg(REG_UNUSED, $urandom);
    settings++;
    calm = 1'b1;
    run_phase(380);
    calm = 1'b0;
    settle();

    // small random gap; the sender holds off mid-phase until all results are in
    write_reg(REG_RESTART_GAP, 32'($urandom_range(200, 1)));
    write_reg(REG_HEADER_BYTES, 32'($urandom_range(255)));
    settings++;
    run_phase(200);
    settle();
    run_phase(200);
    settle();

    if (sb.waiting() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.waiting()));
    $display("Sent %0d headers, checked %0d results across %0d register settings",
             sb.headers, sb.outcomes, settings);
    $display("Seen: %0d complete, %0d restarts, %0d mismatches, %0d old, %0d abandoned",
             sb.tally[CNT_COMPLETE], sb.tally[CNT_RESTART], sb.tally[CNT_MISMATCH],
             sb.tally[CNT_OLD], sb.tally[CNT_INCOMPLETE]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
